[hw/rtl/vtle_pkg.sv]
package vtle_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int BYTE_W       = 8;
  localparam int CHAR_W       = 7;
  localparam int POS_W        = 6;
  localparam int LIMIT_W      = 7;
  localparam int SEQ_W        = 8;
  localparam int SEQ_ACC_W    = 12;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
  localparam logic [SEQ_W-1:0]   SEQ_MAX     = 8'd255;

  localparam logic [SEQ_W-1:0] SEQ_HOME_A = 8'd1;
  localparam logic [SEQ_W-1:0] SEQ_HOME_B = 8'd7;
  localparam logic [SEQ_W-1:0] SEQ_DEL    = 8'd3;
  localparam logic [SEQ_W-1:0] SEQ_END_A  = 8'd4;
  localparam logic [SEQ_W-1:0] SEQ_END_B  = 8'd8;

  localparam logic [CHAR_W-1:0] CH_BS     = 7'h08;
  localparam logic [CHAR_W-1:0] CH_TAB    = 7'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 7'h0D;
  localparam logic [CHAR_W-1:0] CH_ESC    = 7'h1B;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 7'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 7'h39;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 7'h3B;
  localparam logic [CHAR_W-1:0] CH_UP     = 7'h41;
  localparam logic [CHAR_W-1:0] CH_DOWN   = 7'h42;
  localparam logic [CHAR_W-1:0] CH_RIGHT  = 7'h43;
  localparam logic [CHAR_W-1:0] CH_LEFT   = 7'h44;
  localparam logic [CHAR_W-1:0] CH_END    = 7'h46;
  localparam logic [CHAR_W-1:0] CH_HOME   = 7'h48;
  localparam logic [CHAR_W-1:0] CH_SS3    = 7'h4F;
  localparam logic [CHAR_W-1:0] CH_CSI    = 7'h5B;
  localparam logic [CHAR_W-1:0] CH_TILDE  = 7'h7E;
  localparam logic [CHAR_W-1:0] CH_RUBOUT = 7'h7F;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ACT_NONE      = 4'd0,
    ACT_INSERT    = 4'd1,
    ACT_BACKSPACE = 4'd2,
    ACT_DELETE    = 4'd3,
    ACT_LEFT      = 4'd4,
    ACT_RIGHT     = 4'd5,
    ACT_HOME      = 4'd6,
    ACT_END       = 4'd7,
    ACT_PENDING   = 4'd8,
    ACT_UP        = 4'd9,
    ACT_DOWN      = 4'd10,
    ACT_TAB       = 4'd11,
    ACT_FULL      = 4'd12
  } act_t;

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_SEEN = 2'd1,
    ESC_CSI  = 2'd2,
    ESC_SS3  = 2'd3
  } esc_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2,
    OP_EMIT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_DECODE     = 3'd1,
    ST_SHIFT      = 3'd2,
    ST_PUT        = 3'd3,
    ST_EMIT_START = 3'd4,
    ST_EMIT       = 3'd5,
    ST_FINAL      = 3'd6
  } state_t;

  typedef struct packed {
    logic accept;
    logic decode;
    logic shift;
    logic put;
    logic del_done;
    logic emit_rd;
    logic load_char;
    logic load_final;
  } cmd_t;

  typedef struct packed {
    op_t  dec_op;
    op_t  op;
    logic shift_done;
    logic emit_end;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/vtle_ram.sv]
module vtle_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/vtle_ctrl.sv]
module vtle_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  vtle_pkg::sts_t sts,
  output vtle_pkg::cmd_t cmd
);
  import vtle_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (sts.dec_op)
          OP_INS, OP_DEL: state_nxt = ST_SHIFT;
          OP_EMIT:        state_nxt = ST_EMIT_START;
          default:        state_nxt = ST_FINAL;
        endcase
      end
      ST_SHIFT: begin
        if (sts.shift_done) state_nxt = (sts.op == OP_INS) ? ST_PUT : ST_FINAL;
      end
      ST_PUT: begin
        state_nxt = ST_FINAL;
      end
      ST_EMIT_START: begin
        state_nxt = sts.emit_end ? ST_FINAL : ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free && sts.emit_end) state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
      end
      ST_SHIFT: begin
        cmd.shift    = !sts.shift_done;
        cmd.del_done = sts.shift_done && (sts.op == OP_DEL);
      end
      ST_PUT: begin
        cmd.put = 1'b1;
      end
      ST_EMIT_START: begin
        cmd.emit_rd = !sts.emit_end;
      end
      ST_EMIT: begin
        cmd.load_char = sts.out_free;
        cmd.emit_rd   = sts.out_free && !sts.emit_end;
      end
      ST_FINAL: begin
        cmd.load_final = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[hw/rtl/vtle_dp.sv]
module vtle_dp #(
  parameter int LINE_CAPACITY = vtle_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  vtle_pkg::cmd_t                 cmd,
  output vtle_pkg::sts_t                 sts,
  input  logic [vtle_pkg::BYTE_W-1:0]    in_rx_byte,
  input  logic                           cfg_wr_en,
  input  logic [vtle_pkg::LIMIT_W-1:0]   cfg_wr_data,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [1:0]                     out_kind,
  output logic [3:0]                     out_action,
  output logic [vtle_pkg::CHAR_W-1:0]    out_char_code,
  output logic [vtle_pkg::POS_W-1:0]     out_cursor_pos,
  output logic [vtle_pkg::POS_W-1:0]     out_line_length,
  output logic                           out_last
);
  import vtle_pkg::*;

  localparam int IDX_W = $clog2(LINE_CAPACITY);
  localparam logic [LIMIT_W-1:0] CAP_LIM = LIMIT_W'(LINE_CAPACITY);
  localparam logic [LIMIT_W-1:0] MIN_LIM = 7'd2;

  logic [BYTE_W-1:0]  byte_r;
  logic [IDX_W-1:0]   cursor_r, cursor_nxt;
  logic [IDX_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [IDX_W-1:0]   base_r;
  logic [IDX_W-1:0]   pend_addr_r, pend_addr_nxt;
  logic               pend_r, pend_nxt;
  esc_t               esc_r;
  logic [SEQ_W-1:0]   seq_r;
  logic [LIMIT_W-1:0] limit_r;
  op_t                op_r;
  act_t               act_r;

  logic               out_valid_r;
  kind_t              out_kind_r;
  act_t               out_action_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic [POS_W-1:0]   out_cursor_r;
  logic [POS_W-1:0]   out_length_r;
  logic               out_last_r;

  // decode results
  act_t               dec_act;
  op_t                dec_op;
  esc_t               dec_esc;
  logic [SEQ_W-1:0]   dec_seq;
  logic [IDX_W-1:0]   dec_cursor;
  logic [IDX_W-1:0]   dec_base;
  logic [IDX_W-1:0]   dec_ptr;

  logic [LIMIT_W-1:0] lim_eff;
  logic               full;
  logic               shift_up;
  logic               at_stop;
  logic               out_free;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [CHAR_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [CHAR_W-1:0]  ram_rdata;

  vtle_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(LINE_CAPACITY)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (limit_r < MIN_LIM) begin
      lim_eff = MIN_LIM;
    end else if (limit_r > CAP_LIM) begin
      lim_eff = CAP_LIM;
    end else begin
      lim_eff = limit_r;
    end
  end

  assign full = (LIMIT_W'(count_r) >= (lim_eff - 7'd1));

  always_comb begin
    logic [CHAR_W-1:0]    c;
    logic [SEQ_ACC_W-1:0] seq_acc;
    act_t                 key;
    logic                 ins;
    logic                 emit;

    c          = byte_r[CHAR_W-1:0];
    seq_acc    = SEQ_ACC_W'({seq_r, 3'b000}) + SEQ_ACC_W'({seq_r, 1'b0})
                 + SEQ_ACC_W'(c - CH_ZERO);
    key        = ACT_NONE;
    ins        = 1'b0;
    emit       = 1'b0;
    dec_act    = ACT_NONE;
    dec_op     = OP_NONE;
    dec_esc    = esc_r;
    dec_seq    = seq_r;
    dec_cursor = cursor_r;
    dec_base   = cursor_r;

    if (!byte_r[BYTE_W-1]) begin
      case (esc_r)
        ESC_SEEN: begin
          if (c == CH_CSI) begin
            dec_esc = ESC_CSI;
            dec_seq = '0;
            dec_act = ACT_PENDING;
          end else if (c == CH_SS3) begin
            dec_esc = ESC_SS3;
            dec_act = ACT_PENDING;
          end else begin
            dec_esc = ESC_IDLE;
          end
        end
        ESC_SS3: begin
          dec_esc = ESC_IDLE;
          if (c == CH_HOME) key = ACT_HOME;
          else if (c == CH_END) key = ACT_END;
        end
        ESC_CSI: begin
          if (c inside {[CH_ZERO:CH_NINE]}) begin
            dec_seq = (seq_acc > SEQ_ACC_W'(SEQ_MAX)) ? SEQ_MAX : seq_acc[SEQ_W-1:0];
            dec_act = ACT_PENDING;
          end else if (c == CH_SEMI) begin
            dec_act = ACT_PENDING;
          end else begin
            dec_esc = ESC_IDLE;
            case (c)
              CH_UP:    dec_act = ACT_UP;
              CH_DOWN:  dec_act = ACT_DOWN;
              CH_RIGHT: key = ACT_RIGHT;
              CH_LEFT:  key = ACT_LEFT;
              CH_HOME:  key = ACT_HOME;
              CH_END:   key = ACT_END;
              CH_TILDE: begin
                if (seq_r inside {SEQ_HOME_A, SEQ_HOME_B}) key = ACT_HOME;
                else if (seq_r == SEQ_DEL) key = ACT_DELETE;
                else if (seq_r inside {SEQ_END_A, SEQ_END_B}) key = ACT_END;
              end
              default:  dec_act = ACT_NONE;
            endcase
          end
        end
        default: begin
          if (c inside {CH_CR, CH_LF}) begin
            emit = 1'b1;
          end else if (c inside {CH_RUBOUT, CH_BS}) begin
            key = ACT_BACKSPACE;
          end else if (c == CH_TAB) begin
            dec_act = ACT_TAB;
          end else if (c == CH_ESC) begin
            dec_esc = ESC_SEEN;
            dec_act = ACT_PENDING;
          end else if (c >= CH_SPACE && c != CH_RUBOUT) begin
            ins = 1'b1;
          end
        end
      endcase
    end

    if (key != ACT_NONE) dec_act = key;

    case (key)
      ACT_LEFT: begin
        if (cursor_r != '0) dec_cursor = cursor_r - 1'b1;
      end
      ACT_RIGHT: begin
        if (cursor_r < count_r) dec_cursor = cursor_r + 1'b1;
      end
      ACT_HOME: begin
        dec_cursor = '0;
      end
      ACT_END: begin
        dec_cursor = count_r;
      end
      ACT_DELETE: begin
        if (cursor_r < count_r) dec_op = OP_DEL;
      end
      ACT_BACKSPACE: begin
        if (cursor_r != '0) begin
          dec_op   = OP_DEL;
          dec_base = cursor_r - 1'b1;
        end
      end
      default: begin
        dec_cursor = cursor_r;
      end
    endcase

    if (ins) begin
      if (full) begin
        dec_act = ACT_FULL;
      end else begin
        dec_act = ACT_INSERT;
        dec_op  = OP_INS;
      end
    end
    if (emit) dec_op = OP_EMIT;

    case (dec_op)
      OP_INS:  dec_ptr = count_r;
      OP_DEL:  dec_ptr = dec_base + 1'b1;
      default: dec_ptr = '0;
    endcase
  end

  assign shift_up = (op_r == OP_INS);
  assign at_stop  = shift_up ? (ptr_r == cursor_r) : (ptr_r == count_r);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = pend_addr_r;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = ptr_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    cursor_nxt    = cursor_r;
    count_nxt     = count_r;

    if (cmd.decode) begin
      ptr_nxt    = dec_ptr;
      pend_nxt   = 1'b0;
      cursor_nxt = dec_cursor;
    end

    if (cmd.shift) begin
      ram_we = pend_r;
      if (!at_stop) begin
        ram_re        = 1'b1;
        ram_raddr     = shift_up ? ptr_r - 1'b1 : ptr_r;
        pend_nxt      = 1'b1;
        pend_addr_nxt = shift_up ? ptr_r : ptr_r - 1'b1;
        ptr_nxt       = shift_up ? ptr_r - 1'b1 : ptr_r + 1'b1;
      end else begin
        pend_nxt = 1'b0;
      end
    end

    if (cmd.put) begin
      ram_we     = 1'b1;
      ram_waddr  = cursor_r;
      ram_wdata  = byte_r[CHAR_W-1:0];
      cursor_nxt = cursor_r + 1'b1;
      count_nxt  = count_r + 1'b1;
    end

    if (cmd.del_done) begin
      cursor_nxt = base_r;
      count_nxt  = count_r - 1'b1;
    end

    if (cmd.emit_rd) begin
      ram_re    = 1'b1;
      ram_raddr = ptr_r;
      ptr_nxt   = ptr_r + 1'b1;
    end

    if (cmd.load_final && op_r == OP_EMIT) begin
      cursor_nxt = '0;
      count_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      count_r     <= '0;
      esc_r       <= ESC_IDLE;
      seq_r       <= '0;
      limit_r     <= LIMIT_RESET;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cursor_r <= cursor_nxt;
      count_r  <= count_nxt;
      pend_r   <= pend_nxt;
      if (cmd.decode) begin
        esc_r <= dec_esc;
        seq_r <= dec_seq;
      end
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (cmd.load_char || cmd.load_final) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    pend_addr_r <= pend_addr_nxt;
    if (cmd.accept) byte_r <= in_rx_byte;
    if (cmd.decode) begin
      op_r   <= dec_op;
      act_r  <= dec_act;
      base_r <= dec_base;
    end
    if (cmd.load_char) begin
      out_kind_r   <= KIND_CHAR;
      out_action_r <= ACT_NONE;
      out_char_r   <= ram_rdata;
      out_cursor_r <= '0;
      out_length_r <= '0;
      out_last_r   <= 1'b0;
    end else if (cmd.load_final) begin
      out_char_r <= '0;
      out_last_r <= 1'b1;
      if (op_r == OP_EMIT) begin
        out_kind_r   <= KIND_END;
        out_action_r <= ACT_NONE;
        out_cursor_r <= '0;
        out_length_r <= '0;
      end else begin
        out_kind_r   <= KIND_STATUS;
        out_action_r <= act_r;
        out_cursor_r <= POS_W'(cursor_r);
        out_length_r <= POS_W'(count_r);
      end
    end
  end

  assign sts.dec_op     = dec_op;
  assign sts.op         = op_r;
  assign sts.shift_done = at_stop && !pend_r;
  assign sts.emit_end   = (ptr_r == count_r);
  assign sts.out_free   = out_free;

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_action      = out_action_r;
  assign out_char_code   = out_char_r;
  assign out_cursor_pos  = out_cursor_r;
  assign out_line_length = out_length_r;
  assign out_last        = out_last_r;

endmodule

[hw/rtl/vt100_line_editor_top.sv]
// channel | dir | words                         | handshake
// in_     | in  | rx_byte                       | in_valid / in_stall
// out_    | out | kind action char_code cursor_pos line_length last | out_valid / out_stall
// cfg_    | in  | line_limit                    | cfg_wr_en, no wait
//
// Each byte runs from accept to a last result load; the next byte may be
// accepted in the cycle after. Enter emits n line characters, one per cycle
// while the output is not stalled. Insert and delete/backspace shift RAM
// entries one per cycle through the registered read.
// Synchronous active-low reset; no clearing pass. A stalled result holds, and
// the next byte is accepted while it waits; its results wait behind it.
module vt100_line_editor_top #(
  parameter int LINE_CAPACITY = vtle_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [vtle_pkg::BYTE_W-1:0]   in_rx_byte,
  input  logic                          cfg_wr_en,
  input  logic [vtle_pkg::LIMIT_W-1:0]  cfg_wr_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_kind,
  output logic [3:0]                    out_action,
  output logic [vtle_pkg::CHAR_W-1:0]   out_char_code,
  output logic [vtle_pkg::POS_W-1:0]    out_cursor_pos,
  output logic [vtle_pkg::POS_W-1:0]    out_line_length,
  output logic                          out_last
);
  import vtle_pkg::*;

  cmd_t cmd;
  sts_t sts;

  vtle_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  vtle_dp #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_rx_byte     (in_rx_byte),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_action     (out_action),
    .out_char_code  (out_char_code),
    .out_cursor_pos (out_cursor_pos),
    .out_line_length(out_line_length),
    .out_last       (out_last)
  );

`ifndef SYNTH
  a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_STATUS |-> out_cursor_pos <= out_line_length)
    else $error("cursor beyond line end");

  a_line_words_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_STATUS |->
      out_action == ACT_NONE && out_cursor_pos == '0 && out_line_length == '0)
    else $error("line word carries edit state");

  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_line_length) < LINE_CAPACITY)
    else $error("line length exceeds capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second byte taken while first in work");
`endif

endmodule
